// ===== rtl/core/sab_pkg.sv =====
// Package for the splat alpha blend block: payload structs, control codes,
// fixed-point constants and the exp lookup table builder.
// No dependencies.
package sab_pkg;

  localparam int EXP_DEPTH = 256;
  localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [15:0] LIST_CAP = 16'hFFFF;
  localparam logic [15:0] ALPHA_CAP = 16'd64880;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [32:0] STOP_LIMIT = 33'd429497;
  localparam logic [23:0] ACC_MAX = 24'hFFFFFF;
  localparam logic [16:0] OUT_MAX = 17'h1FFFF;

  // Series terms of exp(-8/EXP_DEPTH) in Q0.32, and the resulting step ratio.
  localparam longint unsigned EXP_STEP = (64'd8 << 32) / EXP_DEPTH;
  localparam longint unsigned EXP_T1 = ((64'd1 << 32) * EXP_STEP) >> 32;
  localparam longint unsigned EXP_T2 = ((EXP_T1 * EXP_STEP) >> 32) / 2;
  localparam longint unsigned EXP_T3 = ((EXP_T2 * EXP_STEP) >> 32) / 3;
  localparam longint unsigned EXP_T4 = ((EXP_T3 * EXP_STEP) >> 32) / 4;
  localparam longint unsigned EXP_T5 = ((EXP_T4 * EXP_STEP) >> 32) / 5;
  localparam longint unsigned EXP_T6 = ((EXP_T5 * EXP_STEP) >> 32) / 6;
  localparam longint unsigned EXP_T7 = ((EXP_T6 * EXP_STEP) >> 32) / 7;
  localparam longint unsigned EXP_T8 = ((EXP_T7 * EXP_STEP) >> 32) / 8;
  localparam longint unsigned EXP_T9 = ((EXP_T8 * EXP_STEP) >> 32) / 9;
  localparam longint unsigned EXP_T10 = ((EXP_T9 * EXP_STEP) >> 32) / 10;
  localparam longint unsigned EXP_RATIO = (64'd1 << 32) - EXP_T1 + EXP_T2 - EXP_T3
                                          + EXP_T4 - EXP_T5 + EXP_T6 - EXP_T7
                                          + EXP_T8 - EXP_T9 + EXP_T10;

  typedef enum logic [1:0] {
    MODE_SPLAT = 2'd0,
    MODE_LAST  = 2'd1,
    MODE_EMPTY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_BG_RED    = 2'd0,
    CFG_BG_GREEN  = 2'd1,
    CFG_BG_BLUE   = 2'd2,
    CFG_BG_ENABLE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_UPD,
    ST_ENDM,
    ST_ENDO
  } back_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [31:0] conic_xx;
    logic signed [31:0] conic_xy;
    logic signed [31:0] conic_yy;
    logic [15:0]        opacity;
    logic [15:0]        color_red;
    logic [15:0]        color_green;
    logic [15:0]        color_blue;
  } in_item_t;

  typedef struct packed {
    logic [16:0] out_red;
    logic [16:0] out_green;
    logic [16:0] out_blue;
    logic [16:0] out_transmit;
    logic [15:0] last_contributor;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        skip;
    logic [15:0] alpha;
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
  } qentry_t;

  typedef struct packed {
    logic [15:0] bg_red;
    logic [15:0] bg_green;
    logic [15:0] bg_blue;
    logic        bg_enable;
  } cfg_t;

  typedef logic [15:0] exp_tab_t [EXP_DEPTH];

  function automatic exp_tab_t build_exp_table();
    exp_tab_t tab;
    longint unsigned cur;
    longint unsigned ent;
    cur = 64'd1 << 32;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      ent = (cur + 64'd32768) >> 16;
      tab[i] = (ent > 64'd65535) ? 16'hFFFF : ent[15:0];
      cur = (cur * EXP_RATIO + (64'd1 << 31)) >> 32;
    end
    tab[0] = 16'hFFFF;
    return tab;
  endfunction

endpackage

// ===== rtl/core/splat_alpha_blend.sv =====
// Splat alpha blend: composites depth-sorted Gaussian splats of one pixel front
// to back and returns one result per pixel end. An accepted splat passes a
// seven-stage alpha pipeline into an eight-entry queue, and in_full rises once
// eight splats sit in the pipeline and queue together. The back end pops a skipped
// or ignored splat in the IDLE state and takes a blended one through MUL, ACC and
// UPD, as its transmittance multiply, color multiply and update form one loop. A
// pixel end passes ENDM for the background multiply and ENDO for the result register.
// Depends on sab_pkg, sab_front, sab_queue and sab_back.
module splat_alpha_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sab_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output sab_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  sab_pkg::cfg_t cfg_r;
  logic f_push, q_pop;
  sab_pkg::qentry_t f_entry, q_head;
  logic [2:0] inflight;
  logic [sab_pkg::QPTR_W:0] q_count;
  logic [sab_pkg::QPTR_W+1:0] used;

  assign cfg_ready = 1'b1;
  assign used = {1'b0, q_count} + (sab_pkg::QPTR_W + 2)'(inflight);
  assign in_full = used >= (sab_pkg::QPTR_W + 2)'(sab_pkg::QDEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bg_red <= '0;
      cfg_r.bg_green <= '0;
      cfg_r.bg_blue <= '0;
      cfg_r.bg_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sab_pkg::CFG_BG_RED: cfg_r.bg_red <= cfg_data;
        sab_pkg::CFG_BG_GREEN: cfg_r.bg_green <= cfg_data;
        sab_pkg::CFG_BG_BLUE: cfg_r.bg_blue <= cfg_data;
        sab_pkg::CFG_BG_ENABLE: cfg_r.bg_enable <= cfg_data[0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  sab_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_push && !in_full),
    .item     (in_data),
    .push     (f_push),
    .entry    (f_entry),
    .inflight (inflight)
  );

  sab_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wr_entry (f_entry),
    .pop      (q_pop),
    .head     (q_head),
    .count    (q_count)
  );

  sab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_count == '0),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/sab_front.sv =====
// Front pipeline of the splat alpha blend block: Gaussian power, exp lookup
// and alpha, classifying each splat as blend or skip.
// Depends on sab_pkg.
module sab_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  sab_pkg::in_item_t item,
  output logic              push,
  output sab_pkg::qentry_t  entry,
  output logic [2:0]        inflight
);

  localparam sab_pkg::exp_tab_t ExpTab = sab_pkg::build_exp_table();

  logic [6:0] v_r;

  logic [1:0]  mode_r [7];
  logic [15:0] op_r [7];
  logic [47:0] col_r [7];

  logic signed [24:0] dx1_r, dy1_r;
  logic signed [31:0] cxx1_r, cxy1_r, cyy1_r;

  logic [47:0] sxx2_r, syy2_r, sxy2_r;
  logic [31:0] mxx2_r, myy2_r, mxy2_r;
  logic [2:0]  neg2_r, neg3_r, neg4_r;

  logic [55:0] pxl3_r, pxh3_r, pyl3_r, pyh3_r, pcl3_r, pch3_r;
  logic [80:0] m4_r [3];
  logic signed [82:0] t5_r [3];
  logic signed [82:0] q6_r;
  logic [15:0] ex7_r;

  logic [24:0] dxa, dya;
  logic [23:0] mx, my;
  logic [31:0] mcxx, mcxy, mcyy;
  logic [18:0] e;
  logic [31:0] idx_full;
  logic [15:0] ex;
  logic [31:0] alpha_prod;
  logic [15:0] alpha;
  logic [23:0] alpha_255;
  logic [79:0] mxx4, myy4, mxy4;

  always_comb begin
    dxa = dx1_r[24] ? (~dx1_r + 25'd1) : dx1_r;
    dya = dy1_r[24] ? (~dy1_r + 25'd1) : dy1_r;
    mx = dxa[23:0];
    my = dya[23:0];
    mcxx = cxx1_r[31] ? (~cxx1_r + 32'd1) : cxx1_r;
    mcxy = cxy1_r[31] ? (~cxy1_r + 32'd1) : cxy1_r;
    mcyy = cyy1_r[31] ? (~cyy1_r + 32'd1) : cyy1_r;
    mxx4 = {pxh3_r, 24'h0} + {24'h0, pxl3_r};
    myy4 = {pyh3_r, 24'h0} + {24'h0, pyl3_r};
    mxy4 = {pch3_r, 24'h0} + {24'h0, pcl3_r};
    e = q6_r[43:25];
    idx_full = {13'h0, e} * 32'(sab_pkg::EXP_DEPTH) + 32'd262144;
    idx_full = idx_full >> 19;
    if (q6_r[82] || (q6_r[82:44] != '0) ||
        (idx_full >= 32'(sab_pkg::EXP_DEPTH))) begin
      ex = 16'h0;
    end else begin
      ex = ExpTab[idx_full[sab_pkg::EXP_IDX_W-1:0]];
    end
    alpha_prod = op_r[6] * ex7_r;
    alpha = (alpha_prod[31:16] > sab_pkg::ALPHA_CAP) ? sab_pkg::ALPHA_CAP
                                                     : alpha_prod[31:16];
    alpha_255 = {8'h0, alpha} * 24'd255;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    mode_r[0] <= item.mode;
    op_r[0] <= item.opacity;
    col_r[0] <= {item.color_red, item.color_green, item.color_blue};
    for (int i = 1; i < 7; i++) begin
      mode_r[i] <= mode_r[i-1];
      op_r[i] <= op_r[i-1];
      col_r[i] <= col_r[i-1];
    end
    dx1_r <= {item.center_x[23], item.center_x} - $signed({5'h0, item.pixel_x, 8'h0});
    dy1_r <= {item.center_y[23], item.center_y} - $signed({5'h0, item.pixel_y, 8'h0});
    cxx1_r <= item.conic_xx;
    cxy1_r <= item.conic_xy;
    cyy1_r <= item.conic_yy;

    sxx2_r <= mx * mx;
    syy2_r <= my * my;
    sxy2_r <= mx * my;
    mxx2_r <= mcxx;
    myy2_r <= mcyy;
    mxy2_r <= mcxy;
    neg2_r <= {cxy1_r[31] ^ dx1_r[24] ^ dy1_r[24], cyy1_r[31], cxx1_r[31]};

    pxl3_r <= mxx2_r * sxx2_r[23:0];
    pxh3_r <= mxx2_r * sxx2_r[47:24];
    pyl3_r <= myy2_r * syy2_r[23:0];
    pyh3_r <= myy2_r * syy2_r[47:24];
    pcl3_r <= mxy2_r * sxy2_r[23:0];
    pch3_r <= mxy2_r * sxy2_r[47:24];
    neg3_r <= neg2_r;

    m4_r[0] <= {1'b0, mxx4};
    m4_r[1] <= {1'b0, myy4};
    m4_r[2] <= {mxy4, 1'b0};
    neg4_r <= neg3_r;

    for (int i = 0; i < 3; i++) begin
      t5_r[i] <= neg4_r[i] ? -$signed({2'b00, m4_r[i]}) : $signed({2'b00, m4_r[i]});
    end

    q6_r <= t5_r[0] + t5_r[1] + t5_r[2];
    ex7_r <= ex;
  end

  always_comb begin
    inflight = '0;
    for (int i = 0; i < 7; i++) begin
      inflight = inflight + 3'(v_r[i]);
    end
    push = v_r[6];
    entry.mode = mode_r[6];
    entry.skip = alpha_255 < 24'd65536;
    entry.alpha = alpha;
    entry.color_red = col_r[6][47:32];
    entry.color_green = col_r[6][31:16];
    entry.color_blue = col_r[6][15:0];
  end

endmodule

// ===== rtl/core/sab_queue.sv =====
// Short queue between the front pipeline and the compositing back end.
// Depends on sab_pkg.
module sab_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  sab_pkg::qentry_t        wr_entry,
  input  logic                    pop,
  output sab_pkg::qentry_t        head,
  output logic [sab_pkg::QPTR_W:0] count
);

  sab_pkg::qentry_t mem_r [sab_pkg::QDEPTH];
  logic [sab_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [sab_pkg::QPTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wr_entry;
  end

  assign head = mem_r[rd_r];
  assign count = cnt_r;

endmodule

// ===== rtl/core/sab_back.sv =====
// Back end of the splat alpha blend block: transmittance recurrence, color
// accumulation, background and the result register.
// Depends on sab_pkg.
module sab_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sab_pkg::qentry_t    q_head,
  output logic                q_pop,
  input  sab_pkg::cfg_t       cfg,
  input  logic                out_pop,
  output logic                out_empty,
  output sab_pkg::out_item_t  out_data
);

  sab_pkg::back_state_t state_r, state_nxt;
  sab_pkg::qentry_t cur_r;
  sab_pkg::out_item_t out_r;
  logic out_valid_r;

  logic [16:0] t_r;
  logic [23:0] acc_r [3];
  logic [15:0] lpos_r, contrib_r;
  logic        done_r;
  logic [32:0] next_r, w_r;
  logic [16:0] cp_r [3];
  logic [16:0] bgp_r [3];

  logic hd_count, hd_blend, hd_end, load_out;
  logic [16:0] onem;
  logic [33:0] next_prod;
  logic [32:0] w_prod;
  logic [48:0] cprod [3];
  logic [32:0] bprod [3];
  logic [24:0] asum [3];
  logic [24:0] osum [3];
  logic [16:0] osat [3];
  logic [15:0] col [3];
  logic [15:0] bg [3];

  always_comb begin
    hd_count = (q_head.mode != sab_pkg::MODE_NONE) &&
               (q_head.mode != sab_pkg::MODE_EMPTY) && (lpos_r < sab_pkg::LIST_CAP);
    hd_blend = hd_count && !done_r && !q_head.skip;
    hd_end = (q_head.mode == sab_pkg::MODE_LAST) || (q_head.mode == sab_pkg::MODE_EMPTY);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sab_pkg::ST_IDLE: begin
        if (!q_empty) begin
          if (hd_blend) state_nxt = sab_pkg::ST_MUL;
          else if (hd_end) state_nxt = sab_pkg::ST_ENDM;
        end
      end
      sab_pkg::ST_MUL: state_nxt = sab_pkg::ST_ACC;
      sab_pkg::ST_ACC: state_nxt = sab_pkg::ST_UPD;
      sab_pkg::ST_UPD: begin
        state_nxt = (cur_r.mode == sab_pkg::MODE_LAST) ? sab_pkg::ST_ENDM
                                                       : sab_pkg::ST_IDLE;
      end
      sab_pkg::ST_ENDM: state_nxt = sab_pkg::ST_ENDO;
      sab_pkg::ST_ENDO: begin
        if (!out_valid_r || out_pop) state_nxt = sab_pkg::ST_IDLE;
      end
      default: state_nxt = sab_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == sab_pkg::ST_IDLE) && !q_empty;
    load_out = (state_r == sab_pkg::ST_ENDO) && (!out_valid_r || out_pop);
  end

  always_comb begin
    col[0] = cur_r.color_red;
    col[1] = cur_r.color_green;
    col[2] = cur_r.color_blue;
    bg[0] = cfg.bg_red;
    bg[1] = cfg.bg_green;
    bg[2] = cfg.bg_blue;
    onem = sab_pkg::ONE_Q16 - {1'b0, cur_r.alpha};
    next_prod = {17'h0, t_r} * {17'h0, onem};
    w_prod = {17'h0, cur_r.alpha} * {16'h0, t_r};
    for (int i = 0; i < 3; i++) begin
      cprod[i] = {33'h0, col[i]} * {16'h0, w_r};
      bprod[i] = {16'h0, t_r} * {17'h0, bg[i]};
      asum[i] = {1'b0, acc_r[i]} + {8'h0, cp_r[i]};
      osum[i] = {1'b0, acc_r[i]} + {8'h0, bgp_r[i]};
      osat[i] = (osum[i] > {8'h0, sab_pkg::OUT_MAX}) ? sab_pkg::OUT_MAX : osum[i][16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sab_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      t_r <= sab_pkg::ONE_Q16;
      lpos_r <= '0;
      contrib_r <= '0;
      done_r <= 1'b0;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      if (q_pop && hd_count) lpos_r <= lpos_r + 16'd1;
      if (state_r == sab_pkg::ST_UPD) begin
        if (next_r < sab_pkg::STOP_LIMIT) begin
          done_r <= 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            acc_r[i] <= (asum[i] > {1'b0, sab_pkg::ACC_MAX}) ? sab_pkg::ACC_MAX
                                                              : asum[i][23:0];
          end
          t_r <= next_r[32:16];
          contrib_r <= lpos_r;
        end
      end
      if (load_out) begin
        t_r <= sab_pkg::ONE_Q16;
        lpos_r <= '0;
        contrib_r <= '0;
        done_r <= 1'b0;
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (state_r == sab_pkg::ST_MUL) begin
      next_r <= next_prod[32:0];
      w_r <= w_prod;
    end
    if (state_r == sab_pkg::ST_ACC) begin
      for (int i = 0; i < 3; i++) cp_r[i] <= cprod[i][48:32];
    end
    if (state_r == sab_pkg::ST_ENDM) begin
      for (int i = 0; i < 3; i++) begin
        bgp_r[i] <= cfg.bg_enable ? bprod[i][32:16] : 17'h0;
      end
    end
    if (load_out) begin
      out_r.out_red <= osat[0];
      out_r.out_green <= osat[1];
      out_r.out_blue <= osat[2];
      out_r.out_transmit <= t_r;
      out_r.last_contributor <= contrib_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data = out_r;

endmodule

// ===== rtl/core/sab_checker.sv =====
// Port-level checks for the splat alpha blend block, bound to its top level.
// Depends on sab_pkg and splat_alpha_blend.
module sab_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input sab_pkg::out_item_t out_data
);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result beat dropped without pop");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_data))
    else $error("result beat changed while waiting");

  a_trans: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.out_transmit <= 17'd65536)
    else $error("transmittance above one");

  a_contrib: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.last_contributor != 16'd0) |->
      out_data.out_transmit < 17'd65536)
    else $error("contributor reported with untouched transmittance");

endmodule

bind splat_alpha_blend sab_checker u_sab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
